// ----- src/wildcard_octet_address_rewrite_macros.svh -----
// ----------------------------------------------------------------------------
// Wildcard octet address rewrite: assertion macros
// Check macros clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_OCTET_ADDRESS_REWRITE_MACROS_SVH
`define WILDCARD_OCTET_ADDRESS_REWRITE_MACROS_SVH

// same-cycle implication
`define WOAR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wildcard_octet_address_rewrite: check failed");

// next-cycle implication
`define WOAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wildcard_octet_address_rewrite: check failed");

`endif

// ----- src/woar_pkg.sv -----
// ----------------------------------------------------------------------------
// woar_pkg
// Operation codes, rule entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package woar_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [2:0] NO_WILD_LEVEL = 3'd4;

    // rule entry: source octets, source wildcards, dest octets, dest wildcards
    localparam int ENTRY_W = 72;

    typedef struct packed {
        logic load;        // latch lookup address, restart scan
        logic step;        // read next slot
        logic wr;          // write rule at index
        logic clr;         // clear all valid bits
        logic res_zero;    // load all-zero result
        logic res_lookup;  // load lookup result
    } t_cmd;

    typedef struct packed {
        logic last;        // scan counter at final slot
    } t_sts;

endpackage

// ----- src/woar_ram.sv -----
// ----------------------------------------------------------------------------
// woar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module woar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/woar_ctrl.sv -----
// ----------------------------------------------------------------------------
// woar_ctrl
// Transaction sequencer: accepts commands, walks the rule table, strobes result.
// ----------------------------------------------------------------------------
module woar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    i_operation,
    input  woar_pkg::t_sts i_sts,
    output woar_pkg::t_cmd o_cmd,
    output logic          o_done
);

    import woar_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_done;
    logic       n_done;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_operation == OP_LOOKUP) begin
                        cmd.load = 1'b1;
                        n_state  = ST_SCAN;
                    end else begin
                        cmd.wr       = (i_operation == OP_WRITE);
                        cmd.clr      = (i_operation == OP_CLEAR);
                        cmd.res_zero = 1'b1;
                        n_done       = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                cmd.res_lookup = 1'b1;
                n_done         = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_cmd  = cmd;
    assign o_done = r_done;

endmodule

// ----- src/woar_dp.sv -----
// ----------------------------------------------------------------------------
// woar_dp
// Rule table, valid bits, per-slot match and rewrite, best-rule tracking.
// ----------------------------------------------------------------------------
module woar_dp #(
    parameter int RULE_SLOTS = 16,
    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  woar_pkg::t_cmd i_cmd,
    output woar_pkg::t_sts o_sts,
    input  logic [3:0]     i_rule_index,
    input  logic [31:0]    i_rule_source_pattern,
    input  logic [3:0]     i_rule_source_wild,
    input  logic [31:0]    i_rule_dest_pattern,
    input  logic [3:0]     i_rule_dest_wild,
    input  logic [31:0]    i_lookup_address,
    output logic           o_status,
    output logic [31:0]    o_rewritten_address,
    output logic [2:0]     o_match_level
);

    import woar_pkg::*;

    logic              r_valid [RULE_SLOTS];
    logic [SLOT_W-1:0] r_cnt;
    logic              r_rd_vld;
    logic [31:0]       r_addr;
    logic              r_found;
    logic [2:0]        r_best_level;
    logic [31:0]       r_best_addr;
    logic              r_status;
    logic [31:0]       r_res_addr;
    logic [2:0]        r_res_level;

    logic [8:0]         idx_ext;
    logic               idx_ok;
    logic [SLOT_W-1:0]  waddr;
    logic               we;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;

    logic [31:0] e_src;
    logic [3:0]  e_swild;
    logic [31:0] e_dst;
    logic [3:0]  e_dwild;
    logic        hit;
    logic [2:0]  lvl;
    logic [31:0] res;
    logic [7:0]  a_oct;

    assign idx_ext = 9'(i_rule_index);
    assign idx_ok  = (idx_ext < 9'(RULE_SLOTS));
    assign waddr   = idx_ext[SLOT_W-1:0];
    assign we      = i_cmd.wr && idx_ok;
    assign wdata   = {i_rule_source_pattern, i_rule_source_wild,
                      i_rule_dest_pattern, i_rule_dest_wild};

    woar_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RULE_SLOTS)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_cnt),
        .o_rdata (rdata)
    );

    assign {e_src, e_swild, e_dst, e_dwild} = rdata;

    always_comb begin
        hit   = 1'b1;
        lvl   = NO_WILD_LEVEL;
        res   = '0;
        a_oct = '0;
        for (int p = 0; p < 4; p++) begin
            a_oct = r_addr[31-8*p -: 8];
            if (e_swild[3-p]) begin
                res[31-8*p -: 8] = a_oct;
            end else begin
                if (e_src[31-8*p -: 8] != a_oct) begin
                    hit = 1'b0;
                end
                res[31-8*p -: 8] = e_dwild[3-p] ? a_oct : e_dst[31-8*p -: 8];
            end
        end
        if (e_swild[3]) begin
            lvl = 3'd0;
        end else if (e_swild[2]) begin
            lvl = 3'd1;
        end else if (e_swild[1]) begin
            lvl = 3'd2;
        end else if (e_swild[0]) begin
            lvl = 3'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RULE_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.clr) begin
                for (int i = 0; i < RULE_SLOTS; i++) begin
                    r_valid[i] <= 1'b0;
                end
            end else if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (i_cmd.load) begin
                r_cnt    <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end else begin
                r_rd_vld <= i_cmd.step && r_valid[r_cnt];
                if (i_cmd.step) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_rd_vld && hit && (!r_found || lvl > r_best_level)) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_lookup_address;
        end
        if (r_rd_vld && hit && (!r_found || lvl > r_best_level)) begin
            r_best_level <= lvl;
            r_best_addr  <= res;
        end
        if (i_cmd.res_zero) begin
            r_status    <= 1'b0;
            r_res_addr  <= '0;
            r_res_level <= '0;
        end else if (i_cmd.res_lookup) begin
            r_status    <= !r_found;
            r_res_addr  <= r_found ? r_best_addr : 32'd0;
            r_res_level <= r_found ? r_best_level : 3'd0;
        end
    end

    assign o_sts.last          = (r_cnt == SLOT_W'(RULE_SLOTS - 1));
    assign o_status            = r_status;
    assign o_rewritten_address = r_res_addr;
    assign o_match_level       = r_res_level;

endmodule

// ----- src/wildcard_octet_address_rewrite.sv -----
// ----------------------------------------------------------------------------
// wildcard_octet_address_rewrite
// IPv4 rewrite rule table with per-octet wildcards and longest-prefix lookup.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Signals
//  command   start & !busy          i_operation, i_rule_*, i_lookup_address
//  result    o_done, one cycle      o_status, o_rewritten_address, o_match_level
//
//  Clear, write and unused codes: result strobes the cycle after acceptance.
//  Lookup: the rule RAM is scanned through its single read port, one slot per
//  cycle, then the DRAIN and DONE states pass before the result strobes.
//  busy is high from acceptance of a lookup until its result strobes.
//  Reset empties the table at once through the valid bits.
//  The receiver cannot stall; a new command may be accepted in the strobe cycle.
// ----------------------------------------------------------------------------
`include "wildcard_octet_address_rewrite_macros.svh"

module wildcard_octet_address_rewrite #(
    parameter int RULE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_rule_index,
    input  logic [31:0] i_rule_source_pattern,
    input  logic [3:0]  i_rule_source_wild,
    input  logic [31:0] i_rule_dest_pattern,
    input  logic [3:0]  i_rule_dest_wild,
    input  logic [31:0] i_lookup_address,
    output logic        o_done,
    output logic        o_status,
    output logic [31:0] o_rewritten_address,
    output logic [2:0]  o_match_level
);

    import woar_pkg::*;

    t_cmd cmd;
    t_sts sts;

    woar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_done      (o_done)
    );

    woar_dp #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_rule_index          (i_rule_index),
        .i_rule_source_pattern (i_rule_source_pattern),
        .i_rule_source_wild    (i_rule_source_wild),
        .i_rule_dest_pattern   (i_rule_dest_pattern),
        .i_rule_dest_wild      (i_rule_dest_wild),
        .i_lookup_address      (i_lookup_address),
        .o_status              (o_status),
        .o_rewritten_address   (o_rewritten_address),
        .o_match_level         (o_match_level)
    );

    `WOAR_ASSERT_NEXT(a_short_op_done, start && !busy && i_operation != OP_LOOKUP, o_done && !o_status && o_rewritten_address == 32'd0)
    `WOAR_ASSERT_NEXT(a_lookup_busy, start && !busy && i_operation == OP_LOOKUP, busy && !o_done)
    `WOAR_ASSERT_NOW(a_miss_zero, o_done && o_status, o_rewritten_address == 32'd0 && o_match_level == 3'd0)
    `WOAR_ASSERT_NOW(a_level_range, o_done, o_match_level <= NO_WILD_LEVEL)

endmodule

// ----- tb/sv/tb_wildcard_octet_address_rewrite.sv -----
// ----------------------------------------------------------------------------
// tb_wildcard_octet_address_rewrite
// Drives clear, rule write, lookup and unused commands into the rewrite table.
// A shadow copy of the table predicts each result. A checker compares every
// result strobe, field by field, with the oldest prediction. Directed tests
// cover the field extremes, level priority and tie breaks, and the special
// commands. A random phase follows with bursty command traffic. Its lookups
// are mostly aimed at stored rules.
// ----------------------------------------------------------------------------
module tb_wildcard_octet_address_rewrite;
    import woar_pkg::*;

    localparam int RULE_SLOTS = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1150;

    typedef struct {
        logic        valid;
        logic [31:0] src;
        logic [3:0]  src_wild;
        logic [31:0] dst;
        logic [3:0]  dst_wild;
    } rule_entry_t;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  index;
        logic [31:0] src;
        logic [3:0]  src_wild;
        logic [31:0] dst;
        logic [3:0]  dst_wild;
        logic [31:0] addr;
    } rewrite_cmd_t;

    typedef struct {
        logic        status;
        logic [31:0] addr;
        logic [2:0]  level;
    } rewrite_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [3:0]  i_rule_index;
    logic [31:0] i_rule_source_pattern;
    logic [3:0]  i_rule_source_wild;
    logic [31:0] i_rule_dest_pattern;
    logic [3:0]  i_rule_dest_wild;
    logic [31:0] i_lookup_address;
    logic        o_done;
    logic        o_status;
    logic [31:0] o_rewritten_address;
    logic [2:0]  o_match_level;

    rule_entry_t     rule_table [RULE_SLOTS];
    rewrite_result_t pending_rewrites [$];
    int              error_count = 0;
    int              stalled_cycles = 0;
    int              burst_left = 0;

    wildcard_octet_address_rewrite #(
        .RULE_SLOTS (RULE_SLOTS)
    ) DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_operation           (i_operation),
        .i_rule_index          (i_rule_index),
        .i_rule_source_pattern (i_rule_source_pattern),
        .i_rule_source_wild    (i_rule_source_wild),
        .i_rule_dest_pattern   (i_rule_dest_pattern),
        .i_rule_dest_wild      (i_rule_dest_wild),
        .i_lookup_address      (i_lookup_address),
        .o_done                (o_done),
        .o_status              (o_status),
        .o_rewritten_address   (o_rewritten_address),
        .o_match_level         (o_match_level)
    );

    always #6 i_clk = ~i_clk;

    function automatic rewrite_result_t lookup_rewrite(input logic [31:0] addr);
        rewrite_result_t best;
        logic            found;
        logic            hit;
        logic [2:0]      lvl;
        logic [31:0]     res;
        best = '{status: 1'b1, addr: 32'd0, level: 3'd0};
        found = 1'b0;
        for (int s = 0; s < RULE_SLOTS; s++) begin
            if (rule_table[s].valid) begin
                hit = 1'b1;
                lvl = NO_WILD_LEVEL;
                res = 32'd0;
                for (int p = 0; p < 4; p++) begin
                    if (rule_table[s].src_wild[3 - p]) begin
                        if (lvl == NO_WILD_LEVEL) begin
                            lvl = 3'(p);
                        end
                        res[31 - 8 * p -: 8] = addr[31 - 8 * p -: 8];
                    end else if (rule_table[s].src[31 - 8 * p -: 8] != addr[31 - 8 * p -: 8]) begin
                        hit = 1'b0;
                    end else if (rule_table[s].dst_wild[3 - p]) begin
                        res[31 - 8 * p -: 8] = addr[31 - 8 * p -: 8];
                    end else begin
                        res[31 - 8 * p -: 8] = rule_table[s].dst[31 - 8 * p -: 8];
                    end
                end
                if (hit && (!found || lvl > best.level)) begin
                    found = 1'b1;
                    best = '{status: 1'b0, addr: res, level: lvl};
                end
            end
        end
        return best;
    endfunction

    function automatic rewrite_result_t predict_rewrite(input rewrite_cmd_t cmd);
        rewrite_result_t r;
        r = '{status: 1'b0, addr: 32'd0, level: 3'd0};
        case (cmd.op)
            OP_CLEAR: begin
                for (int s = 0; s < RULE_SLOTS; s++) begin
                    rule_table[s].valid = 1'b0;
                end
            end
            OP_WRITE: begin
                if (int'(cmd.index) < RULE_SLOTS) begin
                    rule_table[cmd.index] = '{valid: 1'b1, src: cmd.src,
                        src_wild: cmd.src_wild, dst: cmd.dst, dst_wild: cmd.dst_wild};
                end
            end
            OP_LOOKUP: begin
                r = lookup_rewrite(cmd.addr);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_octet();
        logic [7:0] common [4];
        common = '{8'h00, 8'hFF, 8'h0A, 8'hC0};
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom);
        end
        return common[$urandom_range(0, 3)];
    endfunction

    function automatic logic [31:0] near_address();
        logic [31:0] a;
        a = rule_table[$urandom_range(0, RULE_SLOTS - 1)].src;
        for (int p = 0; p < 4; p++) begin
            if ($urandom_range(0, 7) == 0) begin
                a[31 - 8 * p -: 8] = pick_octet();
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Drive at the falling edge, hold until accepted, then drop start.
    task automatic send_command(input rewrite_cmd_t cmd);
        int unsigned gap;
        if (burst_left == 0) begin
            start = 1'b0;
            gap = $urandom_range(1, 24);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_operation = cmd.op;
        i_rule_index = cmd.index;
        i_rule_source_pattern = cmd.src;
        i_rule_source_wild = cmd.src_wild;
        i_rule_dest_pattern = cmd.dst;
        i_rule_dest_wild = cmd.dst_wild;
        i_lookup_address = cmd.addr;
        start = 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_rewrites.push_back(predict_rewrite(cmd));
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic rewrite_cmd_t noise_command(input logic [1:0] op);
        rewrite_cmd_t c;
        c = '{op: op, index: 4'($urandom), src: $urandom, src_wild: 4'($urandom),
              dst: $urandom, dst_wild: 4'($urandom), addr: $urandom};
        return c;
    endfunction

    task automatic write_rule(input logic [3:0] index, input logic [31:0] src,
                              input logic [3:0] src_wild, input logic [31:0] dst,
                              input logic [3:0] dst_wild);
        rewrite_cmd_t c;
        c = noise_command(OP_WRITE);
        c.index = index;
        c.src = src;
        c.src_wild = src_wild;
        c.dst = dst;
        c.dst_wild = dst_wild;
        send_command(c);
    endtask

    task automatic lookup_address(input logic [31:0] addr);
        rewrite_cmd_t c;
        c = noise_command(OP_LOOKUP);
        c.addr = addr;
        send_command(c);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending_rewrites.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_empty_table();
        lookup_address(32'h0000_0000);
        lookup_address(32'hFFFF_FFFF);
    endtask

    task automatic test_field_extremes();
        write_rule(4'd0, 32'h0000_0000, 4'b0000, 32'hFFFF_FFFF, 4'b0000);
        write_rule(4'd15, 32'hFFFF_FFFF, 4'b0000, 32'h0000_0000, 4'b1111);
        lookup_address(32'h0000_0000);
        lookup_address(32'hFFFF_FFFF);
        write_rule(4'd7, 32'hDEAD_BEEF, 4'b1111, 32'h1234_5678, 4'b0000);
        lookup_address(32'h1234_5678);
        lookup_address(32'hFFFF_FFFF);
    endtask

    task automatic test_level_priority();
        send_command(noise_command(OP_CLEAR));
        write_rule(4'd3, 32'hC0A8_0000, 4'b0011, 32'h0A0B_0000, 4'b0000);
        write_rule(4'd2, 32'hC0A8_0100, 4'b0001, 32'h0A0B_0D00, 4'b0000);
        write_rule(4'd1, 32'hC0A8_0100, 4'b0001, 32'h0A0B_0C00, 4'b0100);
        write_rule(4'd9, 32'hC000_0A0B, 4'b0100, 32'h1122_3344, 4'b0010);
        lookup_address(32'hC0A8_0105);
        lookup_address(32'hC0A8_FF01);
        lookup_address(32'hC077_0A0B);
        lookup_address(32'hC0A9_0000);
    endtask

    task automatic test_clear_and_unused();
        write_rule(4'd5, 32'h0A00_0001, 4'b0000, 32'h0B00_0002, 4'b0110);
        send_command(noise_command(OP_UNUSED));
        lookup_address(32'h0A00_0001);
        send_command(noise_command(OP_CLEAR));
        lookup_address(32'h0A00_0001);
    endtask

    task automatic test_random_traffic(input int items);
        int unsigned pick;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_command(noise_command(OP_CLEAR));
            end else if (pick < 5) begin
                send_command(noise_command(OP_UNUSED));
            end else if (pick < 45) begin
                write_rule(4'($urandom),
                           {pick_octet(), pick_octet(), pick_octet(), pick_octet()},
                           ($urandom_range(0, 2) == 0) ? 4'($urandom)
                                                       : 4'((1 << $urandom_range(0, 4)) - 1),
                           $urandom, 4'($urandom));
            end else if (pick < 90) begin
                lookup_address(near_address());
            end else begin
                lookup_address(($urandom_range(0, 1) == 0) ? $urandom
                               : {pick_octet(), pick_octet(), pick_octet(), pick_octet()});
            end
            if (n % 200 == 199) begin
                wait_drained();
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        rewrite_result_t want;
        if (i_rst_n === 1'b1) begin
            if ((start && busy === 1'b0) || o_done === 1'b1) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
            if (o_done === 1'b1) begin
                if (pending_rewrites.size() == 0) begin
                    report_mismatch("unexpected result", o_rewritten_address, 32'd0);
                end else begin
                    want = pending_rewrites.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    end
                    if (o_rewritten_address !== want.addr) begin
                        report_mismatch("rewritten_address", o_rewritten_address, want.addr);
                    end
                    if (o_match_level !== want.level) begin
                        report_mismatch("match_level", 32'(o_match_level), 32'(want.level));
                    end
                end
            end
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("wildcard_octet_address_rewrite verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = OP_CLEAR;
        i_rule_index = 4'd0;
        i_rule_source_pattern = 32'd0;
        i_rule_source_wild = 4'd0;
        i_rule_dest_pattern = 32'd0;
        i_rule_dest_wild = 4'd0;
        i_lookup_address = 32'd0;
        for (int s = 0; s < RULE_SLOTS; s++) begin
            rule_table[s] = '{valid: 1'b0, src: 32'd0, src_wild: 4'd0,
                              dst: 32'd0, dst_wild: 4'd0};
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_field_extremes();
        test_level_priority();
        test_clear_and_unused();
        wait_drained();
        test_random_traffic(RANDOM_ITEMS);

        while (pending_rewrites.size() != 0) @(posedge i_clk);
        repeat (RULE_SLOTS + 8) @(posedge i_clk);
        if (error_count == 0 && pending_rewrites.size() == 0) begin
            $display("wildcard_octet_address_rewrite verification clean");
        end else begin
            $display("wildcard_octet_address_rewrite verification failed");
        end
        $finish;
    end
endmodule
